// File: hw/rtl/s256tdw_pkg.sv
// Shared types, round constants and round helper functions for the SHA-256 tail weight block.
package s256tdw_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned NWORDS   = 8;
    localparam int unsigned K_IDX_W  = 6;
    localparam int unsigned CFG_W    = 64;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned NCFG     = 8;
    localparam int unsigned WEIGHT_W = 9;

    // first round of the tail; the constant index wraps modulo 64
    localparam logic [K_IDX_W-1:0] FIRST_ROUND = 6'd57;

    // word 0 is a, word 7 is h
    typedef logic [NWORDS-1:0][WORD_W-1:0] t_state;

    typedef struct packed {
        logic              step;    // beat accepted, advance one round
        logic              reload;  // start of run, take the configured state
        logic [WORD_W-1:0] k;       // round constant for this beat
    } t_lane_ctl;

    localparam logic [WORD_W-1:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

endpackage

// File: hw/rtl/sha256_tail_difference_weight.sv
// Top level: two lockstep SHA-256 tail lanes, configuration registers and weight merge.
// Throughput: one schedule beat per cycle while the merge has room for a run's last
// beat; a run is ROUNDS beats, one round per beat. After the last beat is taken, the
// result passes the XOR, byte-count, group-sum and output registers of the merge pipeline.
// Four merge stages buffer results, so input keeps flowing while a result waits.
// Reset (synchronous, active low) clears the configuration registers, round counter and merge valids.
module sha256_tail_difference_weight #(
    parameter int unsigned ROUNDS = 7
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] word_first, [63:32] word_second
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [8:0] diff_weight, [15:9] zero
    output logic [0:0]  m_axis_tuser,   // [0] match_flag
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [s256tdw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [s256tdw_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int unsigned CNT_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(ROUNDS - 1);

    logic [s256tdw_pkg::CFG_W-1:0] r_cfg [s256tdw_pkg::NCFG];
    logic [CNT_W-1:0]              r_cnt;
    logic [CNT_W-1:0]              n_cnt;
    logic                          last_beat;
    logic                          accept;
    logic                          merge_ready;
    logic [s256tdw_pkg::K_IDX_W-1:0] k_idx;
    s256tdw_pkg::t_lane_ctl        lane_ctl;
    s256tdw_pkg::t_state           init_one;
    s256tdw_pkg::t_state           init_two;
    s256tdw_pkg::t_state           next_one;
    s256tdw_pkg::t_state           next_two;
    logic [s256tdw_pkg::WEIGHT_W-1:0] weight;
    logic                          match;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < s256tdw_pkg::NCFG; i++) begin
                r_cfg[i] <= '0;
            end
        end else if (i_cfg_valid
                     && (i_cfg_index < s256tdw_pkg::CFG_IDX_W'(s256tdw_pkg::NCFG))) begin
            r_cfg[i_cfg_index[2:0]] <= i_cfg_data;
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            init_one[2*i]   = r_cfg[i][63:32];
            init_one[2*i+1] = r_cfg[i][31:0];
            init_two[2*i]   = r_cfg[4+i][63:32];
            init_two[2*i+1] = r_cfg[4+i][31:0];
        end
    end

    // the last beat of a run needs room in the merge pipeline
    assign last_beat     = (r_cnt == LAST_CNT);
    assign s_axis_tready = !last_beat || merge_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign n_cnt         = last_beat ? '0 : r_cnt + CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (accept) begin
            r_cnt <= n_cnt;
        end
    end

    assign k_idx = s256tdw_pkg::FIRST_ROUND + s256tdw_pkg::K_IDX_W'(r_cnt);

    always_comb begin
        lane_ctl.step   = accept;
        lane_ctl.reload = (r_cnt == '0);
        lane_ctl.k      = s256tdw_pkg::K_TABLE[k_idx];
    end

    s256tdw_lane u_lane_one (
        .i_clk  (i_clk),
        .i_ctl  (lane_ctl),
        .i_init (init_one),
        .i_word (s_axis_tdata[31:0]),
        .o_next (next_one)
    );

    s256tdw_lane u_lane_two (
        .i_clk  (i_clk),
        .i_ctl  (lane_ctl),
        .i_init (init_two),
        .i_word (s_axis_tdata[63:32]),
        .o_next (next_two)
    );

    s256tdw_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept && last_beat),
        .o_ready     (merge_ready),
        .i_state_one (next_one),
        .i_state_two (next_two),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_weight    (weight),
        .o_match     (match)
    );

    assign m_axis_tdata = {7'd0, weight};
    assign m_axis_tuser = match;

endmodule

// File: hw/rtl/s256tdw_lane.sv
// One lane: working state a..h of one message and its compression round.
module s256tdw_lane (
    input  logic                          i_clk,
    input  s256tdw_pkg::t_lane_ctl        i_ctl,
    input  s256tdw_pkg::t_state           i_init,
    input  logic [s256tdw_pkg::WORD_W-1:0] i_word,
    output s256tdw_pkg::t_state           o_next
);

    s256tdw_pkg::t_state r_words;
    s256tdw_pkg::t_state cur;
    logic [s256tdw_pkg::WORD_W-1:0] t1;
    logic [s256tdw_pkg::WORD_W-1:0] t2;
    logic [s256tdw_pkg::WORD_W-1:0] choose;
    logic [s256tdw_pkg::WORD_W-1:0] major;

    always_comb begin
        cur    = i_ctl.reload ? i_init : r_words;
        choose = (cur[4] & cur[5]) ^ (~cur[4] & cur[6]);
        major  = (cur[0] & cur[1]) ^ (cur[0] & cur[2]) ^ (cur[1] & cur[2]);
        t1     = cur[7] + s256tdw_pkg::big_sigma1(cur[4]) + choose + i_ctl.k + i_word;
        t2     = s256tdw_pkg::big_sigma0(cur[0]) + major;
        o_next[7] = cur[6];
        o_next[6] = cur[5];
        o_next[5] = cur[4];
        o_next[4] = cur[3] + t1;
        o_next[3] = cur[2];
        o_next[2] = cur[1];
        o_next[1] = cur[0];
        o_next[0] = t1 + t2;
    end

    // payload only: every run starts with a reload
    always_ff @(posedge i_clk) begin
        if (i_ctl.step) begin
            r_words <= o_next;
        end
    end

endmodule

// File: hw/rtl/s256tdw_merge.sv
// Merge pipeline: XOR of both lane states, registered popcount tree, output register.
module s256tdw_merge (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    output logic                               o_ready,
    input  s256tdw_pkg::t_state                i_state_one,
    input  s256tdw_pkg::t_state                i_state_two,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [s256tdw_pkg::WEIGHT_W-1:0]   o_weight,
    output logic                               o_match
);

    localparam int unsigned NBYTES = 32;
    localparam int unsigned NGRP   = 4;
    localparam int unsigned GRP_SZ = NBYTES / NGRP;

    logic [3:0]                          r_vld;
    logic [255:0]                        r_xor;
    logic [NBYTES-1:0][3:0]              r_bytes;
    logic [NBYTES-1:0][3:0]              n_bytes;
    logic [NGRP-1:0][6:0]                r_grp;
    logic [NGRP-1:0][6:0]                n_grp;
    logic [s256tdw_pkg::WEIGHT_W-1:0]    r_weight;
    logic [s256tdw_pkg::WEIGHT_W-1:0]    n_weight;
    logic                                r_match;
    logic [3:0]                          rdy;

    // a stage takes data when empty or when its content moves on
    always_comb begin
        rdy[3] = !r_vld[3] || i_ready;
        rdy[2] = !r_vld[2] || rdy[3];
        rdy[1] = !r_vld[1] || rdy[2];
        rdy[0] = !r_vld[0] || rdy[1];
    end

    always_comb begin
        for (int i = 0; i < NBYTES; i++) begin
            n_bytes[i] = 4'd0;
            for (int j = 0; j < 8; j++) begin
                n_bytes[i] = n_bytes[i] + {3'd0, r_xor[8*i+j]};
            end
        end
    end

    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_grp[g] = 7'd0;
            for (int j = 0; j < GRP_SZ; j++) begin
                n_grp[g] = n_grp[g] + {3'd0, r_bytes[g*GRP_SZ+j]};
            end
        end
    end

    always_comb begin
        n_weight = '0;
        for (int g = 0; g < NGRP; g++) begin
            n_weight = n_weight + {2'd0, r_grp[g]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) r_vld[0] <= i_push;
            if (rdy[1]) r_vld[1] <= r_vld[0];
            if (rdy[2]) r_vld[2] <= r_vld[1];
            if (rdy[3]) r_vld[3] <= r_vld[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0] && i_push) begin
            r_xor <= i_state_one ^ i_state_two;
        end
        if (rdy[1] && r_vld[0]) begin
            r_bytes <= n_bytes;
        end
        if (rdy[2] && r_vld[1]) begin
            r_grp <= n_grp;
        end
        if (rdy[3] && r_vld[2]) begin
            r_weight <= n_weight;
            r_match  <= (n_weight == '0);
        end
    end

    assign o_ready  = rdy[0];
    assign o_valid  = r_vld[3];
    assign o_weight = r_weight;
    assign o_match  = r_match;

endmodule
